[sv/hashed_timing_wheel_assert.svh]
// Assertion macros for the timer wheel checker
`ifndef HASHED_TIMING_WHEEL_ASSERT_SVH
`define HASHED_TIMING_WHEEL_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define HTW_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer wheel check failed");

// Next-cycle implication, disabled in reset
`define HTW_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer wheel check failed");

`endif

[sv/htw_pkg.sv]
`default_nettype none
package htw_pkg;

  localparam int unsigned IdW  = 5;
  localparam int unsigned ExpW = 16;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REFRESH = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  // One classified command between front and back
  typedef struct packed {
    op_e             op;
    logic            skip;
    logic [IdW-1:0]  id;
    logic [ExpW-1:0] expiry;
  } cmd_t;

endpackage
`default_nettype wire

[sv/htw_front.sv]
`default_nettype none
module htw_front #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [4:0]        timer_id_i,
  input  wire logic [15:0]       expire_ticks_i,
  output logic                   cmd_valid_o,
  output htw_pkg::cmd_t          cmd_o,
  input  wire logic              cmd_pop_i
);
  import htw_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       push;

  // Classify the incoming beat
  always_comb begin
    cls.op     = op_e'(operation_i);
    cls.id     = timer_id_i;
    cls.skip   = (cls.op != OP_TICK) && (32'(timer_id_i) >= NUM_TIMERS);
    cls.expiry = expire_ticks_i;
    if (cls.op == OP_ADD && expire_ticks_i == '0) begin
      cls.expiry = 16'd1;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];

  // Advance queue pointers
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = cmd_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the command
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

[sv/htw_back.sv]
`default_nettype none
module htw_back #(
  parameter int unsigned WHEEL_SLOTS = 32,
  parameter int unsigned NUM_TIMERS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire htw_pkg::cmd_t cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             event_kind_o,
  output logic [4:0]       fired_id_o,
  output logic             last_o
);
  import htw_pkg::*;

  localparam int unsigned NT = (NUM_TIMERS < 32) ? NUM_TIMERS : 32;
  localparam int unsigned IW = (NT > 1) ? $clog2(NT) : 1;
  localparam int unsigned SW = $clog2(WHEEL_SLOTS);
  localparam int unsigned RW = $clog2(65535 / WHEEL_SLOTS + 1) > 0 ?
                               $clog2(65535 / WHEEL_SLOTS + 1) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST} state_e;

  state_e          state_q;
  logic [SW-1:0]   pos_q;
  logic [IW-1:0]   cnt_q;
  logic            pend_v_q;
  logic [IW-1:0]   pend_id_q;
  logic [NT-1:0]   present_q, enabled_q;
  logic            out_v_q, kind_q, last_q;
  logic [4:0]      id_q;

  logic [SW-1:0]   due_q    [NT];
  logic [RW-1:0]   rounds_q [NT];
  logic [15:0]     first_q  [NT];

  logic            free, idle_go, scan_go;
  logic [IW-1:0]   cidx, sidx;
  logic [15:0]     esel, em1;
  logic [16:0]     sum;
  logic [SW-1:0]   due_n, pos_n;
  logic [RW-1:0]   rounds_n;
  logic            arm_we, first_we, dec_we;
  logic            hit, expire, fire;
  logic            add_fire, out_load;

  assign free      = !out_v_q || out_ready_i;
  assign idle_go   = (state_q == ST_IDLE) && cmd_valid_i && free;
  assign scan_go   = (state_q == ST_SCAN) && free;
  assign cmd_pop_o = idle_go;
  assign cidx      = cmd_i.id[IW-1:0];
  assign sidx      = cnt_q;

  // Arm: slot and rounds from the chosen expiry (wheel size is a power of two)
  always_comb begin
    esel = cmd_i.expiry;
    if (cmd_i.op == OP_REFRESH && cmd_i.expiry == '0) begin
      esel = first_q[cidx];
    end
    if (esel == '0) begin
      esel = 16'd1;
    end
    em1      = esel - 16'd1;
    sum      = 17'(pos_q) + 17'(esel);
    due_n    = sum[SW-1:0];
    rounds_n = RW'(em1 >> SW);
    pos_n    = (32'(pos_q) == WHEEL_SLOTS - 1) ? '0 : pos_q + SW'(1);
  end

  // Scan step on one record
  always_comb begin
    hit    = present_q[sidx] && (due_q[sidx] == pos_q);
    expire = hit && (rounds_q[sidx] == '0);
    fire   = expire && enabled_q[sidx];
    dec_we = scan_go && hit && !expire;
  end

  always_comb begin
    arm_we   = idle_go && !cmd_i.skip &&
               ((cmd_i.op == OP_ADD) || (cmd_i.op == OP_REFRESH && present_q[cidx]));
    first_we = idle_go && !cmd_i.skip && (cmd_i.op == OP_ADD);
  end

  // Load the result register on a new beat
  assign add_fire = (cmd_i.op == OP_ADD) && !cmd_i.skip &&
                    present_q[cidx] && enabled_q[cidx];
  assign out_load = (idle_go && (cmd_i.op != OP_TICK)) ||
                    (scan_go && fire && pend_v_q) ||
                    ((state_q == ST_LAST) && free);

  // Record storage
  always_ff @(posedge clk_i) begin
    if (arm_we) begin
      due_q[cidx]    <= due_n;
      rounds_q[cidx] <= rounds_n;
    end else if (dec_we) begin
      rounds_q[sidx] <= rounds_q[sidx] - RW'(1);
    end
    if (first_we) begin
      first_q[cidx] <= esel;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      cnt_q     <= '0;
      pend_v_q  <= 1'b0;
      pend_id_q <= '0;
      present_q <= '0;
      enabled_q <= '0;
      out_v_q   <= 1'b0;
      kind_q    <= 1'b0;
      last_q    <= 1'b0;
      id_q      <= '0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (idle_go) begin
            if (cmd_i.op == OP_TICK) begin
              pos_q    <= pos_n;
              cnt_q    <= '0;
              pend_v_q <= 1'b0;
              state_q  <= ST_SCAN;
            end else begin
              kind_q <= add_fire;
              id_q   <= add_fire ? cmd_i.id : 5'd0;
              last_q <= 1'b1;
              if (!cmd_i.skip) begin
                if (cmd_i.op == OP_ADD) begin
                  present_q[cidx] <= 1'b1;
                  enabled_q[cidx] <= 1'b1;
                end else if (cmd_i.op == OP_CANCEL) begin
                  enabled_q[cidx] <= 1'b0;
                end
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            if (expire) begin
              present_q[sidx] <= 1'b0;
              enabled_q[sidx] <= 1'b0;
            end
            // Emit the held firing once a later one shows up
            if (fire) begin
              if (pend_v_q) begin
                kind_q  <= 1'b1;
                id_q    <= 5'(pend_id_q);
                last_q  <= 1'b0;
              end
              pend_v_q  <= 1'b1;
              pend_id_q <= sidx;
            end
            if (32'(cnt_q) == NT - 1) begin
              state_q <= ST_LAST;
            end else begin
              cnt_q <= cnt_q + IW'(1);
            end
          end
        end
        ST_LAST: begin
          if (free) begin
            kind_q  <= pend_v_q;
            id_q    <= pend_v_q ? 5'(pend_id_q) : 5'd0;
            last_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_v_q;
  assign event_kind_o = kind_q;
  assign fired_id_o   = id_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

[sv/hashed_timing_wheel.sv]
// Hashed timing wheel timer engine.
// Input channel (in_valid_i/in_ready_o) carries one command per beat:
// operation_i (add, refresh, cancel, tick), timer_id_i, expire_ticks_i.
// Output channel (out_valid_o/out_ready_i) returns result beats:
// event_kind_o, fired_id_o, last_o. Every command yields at least one beat;
// last_o marks its final beat. A tick reports each fired timer in ascending
// id order, or one empty beat if none fired.
// Add, refresh and cancel each load the result register when the engine takes
// them from the queue. A tick walks every timer record once, one record per
// cycle while the receiver does not stall the result register; that record
// walk sets the tick rate.
// WHEEL_SLOTS must be a power of two.
// A two-entry command queue keeps accepting while the engine works.
// When the receiver stalls, the result register holds and the engine waits;
// the queue fills and then in_ready_o drops.
// Reset clears the wheel position and all timers; no clearing pass is needed.
`default_nettype none
module hashed_timing_wheel #(
  parameter int unsigned WHEEL_SLOTS = 32,
  parameter int unsigned NUM_TIMERS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [4:0]  timer_id_i,
  input  wire logic [15:0] expire_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             event_kind_o,
  output logic [4:0]       fired_id_o,
  output logic             last_o
);
  import htw_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  htw_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .timer_id_i,
    .expire_ticks_i, .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  htw_back #(.WHEEL_SLOTS(WHEEL_SLOTS), .NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .out_valid_o, .out_ready_i, .event_kind_o, .fired_id_o, .last_o
  );

endmodule
`default_nettype wire

[sv/htw_checker.sv]
`default_nettype none
`include "hashed_timing_wheel_assert.svh"
module htw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       event_kind_o,
  input wire logic [4:0] fired_id_o,
  input wire logic       last_o
);
  // Hold a stalled result beat
  `HTW_AST_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `HTW_AST_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(fired_id_o) && $stable(last_o))
  // An empty beat is always alone and carries id zero
  `HTW_AST_NOW(a_empty_id, out_valid_o && !event_kind_o, fired_id_o == 5'd0)
  `HTW_AST_NOW(a_empty_last, out_valid_o && !event_kind_o, last_o)
endmodule

bind hashed_timing_wheel htw_checker u_htw_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i), .event_kind_o(event_kind_o),
  .fired_id_o(fired_id_o), .last_o(last_o)
);
`default_nettype wire

[bench/hashed_timing_wheel_checker.sv]
`default_nettype none
module hashed_timing_wheel_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  operation_i,
  input  wire logic [4:0]  timer_id_i,
  input  wire logic [15:0] expire_ticks_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        event_kind_i,
  input  wire logic [4:0]  fired_id_i,
  input  wire logic        last_i,
  output int               fail_count_o,
  output int               pending_o
);
  import htw_pkg::*;

  localparam int unsigned Slots  = 32;
  localparam int unsigned Timers = 32;

  typedef struct packed {
    logic       kind;
    logic [4:0] id;
    logic       last;
  } beat_t;

  // wheel image
  logic [4:0]  wheel_pos;
  logic        armed    [Timers];
  logic        live     [Timers];
  logic [15:0] start_exp[Timers];
  logic [4:0]  slot_of  [Timers];
  logic [10:0] laps_of  [Timers];

  beat_t expected_beats[$];
  int    reported;

  // append one expected beat
  function automatic void queue_beat(logic kind, logic [4:0] id, logic last);
    beat_t b;
    b.kind = kind;
    b.id = id;
    b.last = last;
    expected_beats = {expected_beats, b};
  endfunction

  function automatic void place_timer(int unsigned id, logic [15:0] ex);
    logic [16:0] sum;
    sum = 17'(wheel_pos) + 17'(ex);
    slot_of[id] = 5'(sum % Slots);
    laps_of[id] = 11'((ex - 16'd1) / 16'(Slots));
  endfunction

  // advance the image by one command, queue the beats it causes
  function automatic void predict_command(op_e op, logic [4:0] id, logic [15:0] ex);
    logic [15:0] e;
    int          n;
    n = 0;
    if (op == OP_TICK) begin
      wheel_pos = wheel_pos + 5'd1;
      for (int i = 0; i < Timers; i++) begin
        if (armed[i] && slot_of[i] == wheel_pos) begin
          if (laps_of[i] != 0) begin
            laps_of[i] = laps_of[i] - 11'd1;
          end else begin
            armed[i] = 1'b0;
            if (live[i]) begin
              queue_beat(1'b1, 5'(i), 1'b0);
              n++;
            end
            live[i] = 1'b0;
          end
        end
      end
      if (n == 0) queue_beat(1'b0, 5'd0, 1'b1);
      else expected_beats[$].last = 1'b1;
      return;
    end
    if (op == OP_ADD) begin
      e = (ex == 0) ? 16'd1 : ex;
      if (armed[id] && live[id]) queue_beat(1'b1, id, 1'b1);
      else queue_beat(1'b0, 5'd0, 1'b1);
      armed[id] = 1'b1;
      live[id] = 1'b1;
      start_exp[id] = e;
      place_timer(id, e);
      return;
    end
    if (op == OP_REFRESH && armed[id]) begin
      e = (ex == 0) ? start_exp[id] : ex;
      if (e == 0) e = 16'd1;
      place_timer(id, e);
    end
    if (op == OP_CANCEL && armed[id]) live[id] = 1'b0;
    queue_beat(1'b0, 5'd0, 1'b1);
  endfunction

  // track commands and compare result beats
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want;
    if (!rst_ni) begin
      wheel_pos = '0;
      for (int i = 0; i < Timers; i++) begin
        armed[i] = 1'b0;
        live[i] = 1'b0;
        start_exp[i] = '0;
        slot_of[i] = '0;
        laps_of[i] = '0;
      end
      expected_beats.delete();
      fail_count_o = 0;
      reported = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          fail_count_o++;
          if (reported < 10) begin
            reported++;
            $display("unexpected beat kind=%0d id=%0d last=%0d",
                     event_kind_i, fired_id_i, last_i);
          end
        end else begin
          want = expected_beats.pop_front();
          if (want != {event_kind_i, fired_id_i, last_i}) begin
            fail_count_o++;
            if (reported < 10) begin
              reported++;
              $display("beat mismatch: expected kind=%0d id=%0d last=%0d, got %0d %0d %0d",
                       want.kind, want.id, want.last, event_kind_i, fired_id_i, last_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predict_command(op_e'(operation_i), timer_id_i, expire_ticks_i);
    end
    pending_o = expected_beats.size();
  end
endmodule
`default_nettype wire

[bench/hashed_timing_wheel_test.sv]
`default_nettype none
module hashed_timing_wheel_test;
  import htw_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [4:0]  timer_id_i;
  logic [15:0] expire_ticks_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        event_kind_o;
  logic [4:0]  fired_id_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int          cycle_count;
  bit          hold_off_req;
  bit          hold_off_done;

  hashed_timing_wheel u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .timer_id_i,
    .expire_ticks_i, .out_valid_o, .out_ready_i, .event_kind_o, .fired_id_o, .last_o
  );

  hashed_timing_wheel_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .timer_id_i,
    .expire_ticks_i, .out_valid_i(out_valid_o), .out_ready_i, .event_kind_i(event_kind_o),
    .fired_id_i(fired_id_o), .last_i(last_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // pick a gap length: mostly zero or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one command beat, hold until accepted; valid stays up for the next one
  task automatic send_cmd(op_e op, logic [4:0] id, logic [15:0] ex);
    operation_i <= op;
    timer_id_i <= id;
    expire_ticks_i <= ex;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // drop valid for a random number of cycles
  task automatic send_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // random expiry, mostly short so timers come due often
  function automatic logic [15:0] rand_expiry();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 40));
    if (r < 90) return 16'($urandom_range(41, 200));
    return 16'($urandom);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ready_i = 1'b0;
    hold_off_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 1'b0;
        n = 0;
        while (n < 200) begin
          @(negedge clk_i);
          n++;
        end
        hold_off_done = 1'b1;
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(negedge clk_i);
        end
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = '0;
    timer_id_i = '0;
    expire_ticks_i = '0;
    hold_off_req = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, zero expiry, re-add, cancel, refresh reuse, absent ids
    send_cmd(OP_TICK, 5'd0, 16'd0);
    send_cmd(OP_REFRESH, 5'd3, 16'd5);
    send_cmd(OP_CANCEL, 5'd4, 16'd0);
    send_cmd(OP_ADD, 5'd0, 16'd0);
    send_cmd(OP_ADD, 5'd31, 16'd1);
    send_cmd(OP_ADD, 5'd5, 16'd33);
    send_cmd(OP_ADD, 5'd6, 16'hFFFF);
    send_cmd(OP_ADD, 5'd7, 16'd2);
    send_cmd(OP_ADD, 5'd7, 16'd3);
    send_cmd(OP_ADD, 5'd8, 16'd2);
    send_cmd(OP_CANCEL, 5'd8, 16'd0);
    send_cmd(OP_ADD, 5'd8, 16'd4);
    send_cmd(OP_ADD, 5'd9, 16'd1);
    send_cmd(OP_REFRESH, 5'd9, 16'd0);
    send_cmd(OP_ADD, 5'd10, 16'd2);
    send_cmd(OP_CANCEL, 5'd10, 16'd0);
    send_cmd(OP_REFRESH, 5'd10, 16'd1);
    send_cmd(OP_ADD, 5'd21, 16'd32);
    send_cmd(OP_ADD, 5'd2, 16'd64);
    repeat (4) send_cmd(OP_TICK, 5'd31, 16'hFFFF);
    // all 32 timers due in one tick
    for (int i = 0; i < 32; i++) send_cmd(OP_ADD, 5'(i), 16'd1);
    send_cmd(OP_TICK, 5'd0, 16'd0);

    // random: mostly adds and ticks, ids and expiries random
    for (int k = 0; k < 414; k++) begin
      if (k == 150) hold_off_req = 1'b1;
      if (k == 300) begin
        in_valid_i <= 1'b0;
        wait (pending == 0);
        repeat (40) @(negedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 35) send_cmd(OP_ADD, 5'($urandom), rand_expiry());
      else if (r < 50) send_cmd(OP_REFRESH, 5'($urandom), rand_expiry());
      else if (r < 60) send_cmd(OP_CANCEL, 5'($urandom), 16'($urandom));
      else send_cmd(OP_TICK, 5'($urandom), 16'($urandom));
      if (k % 60 > 40) send_gap();
    end

    in_valid_i <= 1'b0;
    wait (hold_off_done);
    wait (pending == 0);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
